// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the PID correction step block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition on the same clock edge as the antecedent.
`define PCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Condition on the clock edge after the antecedent.
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// PID correction step package
// Widths, limits, state encoding and control structures shared by the block.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int ERR_W     = 15;
   localparam int MS_W      = 16;
   localparam int GAIN_W    = 16;
   localparam int CORR_W    = 20;
   localparam int ACC_W     = 32;
   localparam int DIFF_W    = 16;
   localparam int MSC_W     = 10;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int DIV_W     = 48;
   localparam int SUM_W     = 48;
   localparam int CSR_IDX_W = 2;

   // Quotient bits retired per divider cycle.
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_STEPS      = DIV_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = CSR_IDX_W'(2);

   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = GAIN_W'(384);
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = GAIN_W'(0);
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = GAIN_W'(0);

   localparam logic signed [ACC_W:0] ACC_LIMIT = (ACC_W+1)'(1280000000);
   localparam int OUT_LIMIT   = 512000;
   localparam int OUT_SHIFT   = 8;
   localparam int OUT_ROUND   = (1 << OUT_SHIFT) - 1;
   localparam int MS_MAX      = 1000;
   localparam int MS_SCALE    = 1000;
   localparam int INTEG_SCALE = 1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC_MUL,
      ST_ACC_UPD,
      ST_P_TERM,
      ST_I_TERM,
      ST_D_GAIN,
      ST_D_TERM,
      ST_I_DIV,
      ST_D_DIV,
      ST_OUTPUT
   } pcs_state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [MSC_W-1:0]   divisor;
   } pcs_div_req_type;

   typedef struct packed {
      logic               busy;
      logic [DIV_W-1:0]   quotient;
   } pcs_div_rsp_type;

endpackage

// File: rtl/pcs_if.sv
// ----------------------------------------------------------------------------
// PID correction step channels
// Valid/ready interfaces for the request and response transactions.
// ----------------------------------------------------------------------------
interface pcs_req_if;
   import pcs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ERR_W-1:0]  line_error;
   logic [MS_W-1:0]          elapsed_ms;

   modport source (output valid, line_error, elapsed_ms, input ready);
   modport sink   (input valid, line_error, elapsed_ms, output ready);
endinterface

interface pcs_rsp_if;
   import pcs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CORR_W-1:0] correction;
   logic                     output_saturated;

   modport source (output valid, correction, output_saturated, input ready);
   modport sink   (input valid, correction, output_saturated, output ready);
endinterface

// File: rtl/pcs_multiplier.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused for every term.
// ----------------------------------------------------------------------------
module pcs_multiplier (
   input  logic                              clock,
   input  logic signed [pcs_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [pcs_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [pcs_pkg::PROD_W-1:0]  product_ff
);
   import pcs_pkg::*;

   logic signed [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// File: rtl/pcs_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider retiring four quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcs_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  pcs_pkg::pcs_div_req_type div_req,
   output pcs_pkg::pcs_div_rsp_type div_rsp
);
   import pcs_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     quo_in;
   logic [MSC_W-1:0]     rem_ff;
   logic [MSC_W-1:0]     rem_in;
   logic [MSC_W-1:0]     divisor_ff;
   logic                 last_step;

   // The dividend shifts out of the top of quo_ff while quotient bits enter
   // at the bottom, so after all steps the register holds the quotient.
   always_comb begin
      logic [MSC_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         trial  = {rem_in, quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial     = trial - {1'b0, divisor_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[MSC_W-1:0];
      end
   end

   assign last_step = (count_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (div_req.start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff     <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = quo_ff;

   `PCS_ASSERT_IMPL(a_no_restart, clock, reset, div_req.start, !busy_ff)
   `PCS_ASSERT_NEXT(a_start_busy, clock, reset, div_req.start, busy_ff && (count_ff == '0))
   `PCS_ASSERT_IMPL(a_rem_below, clock, reset, busy_ff, rem_ff < divisor_ff)

endmodule

// File: rtl/pid_correction_step.sv
// Sequencing: the first transaction after reset goes straight to ST_OUTPUT with
// a zero correction; later ones pass ST_ACC_MUL, ST_ACC_UPD, ST_P_TERM, ST_I_TERM,
// ST_D_GAIN, ST_D_TERM, the integral and derivative divider passes and ST_OUTPUT,
// which waits on a held response. A request is taken only in ST_IDLE.
// Reset: gains return to 1.5 / 0 / 0, integral and previous error clear, and
// the next transaction is treated as the first.
// ----------------------------------------------------------------------------
// PID correction step
// Fixed-point PID steering correction with a saturating integral term.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_correction_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcs_pkg::GAIN_W-1:0]        csr_wdata,
   pcs_req_if.sink                           req_chan,
   pcs_rsp_if.source                         rsp_chan
);
   import pcs_pkg::*;

   pcs_state_type              state_ff;
   pcs_state_type              state_in;

   logic [GAIN_W-1:0]          prop_ff;
   logic [GAIN_W-1:0]          integ_ff;
   logic [GAIN_W-1:0]          deriv_ff;

   logic                       primed_ff;
   logic signed [ERR_W-1:0]    prev_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ERR_W-1:0]    err_ff;
   logic [MSC_W-1:0]           ms_ff;
   logic [MSC_W-1:0]           ms_clamped;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [DIV_W-1:0]           dnum_ff;
   logic                       dneg_ff;
   logic                       ineg_ff;

   logic                       rsp_valid_ff;
   logic signed [CORR_W-1:0]   rsp_corr_ff;
   logic                       rsp_sat_ff;

   logic                       req_fire;
   logic                       rsp_load;
   logic                       quo_take;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   product_ff;
   logic [PROD_W-1:0]          prod_mag;

   pcs_div_req_type            div_req;
   pcs_div_rsp_type            div_rsp;

   logic signed [ACC_W:0]      acc_sum;
   logic signed [ACC_W:0]      acc_sat;
   logic signed [DIV_W:0]      quo_ext;
   logic signed [DIV_W:0]      quo_term;
   logic signed [SUM_W-1:0]    sum_biased;
   logic signed [SUM_W-1:0]    sum_scaled;
   logic signed [CORR_W-1:0]   corr_value;
   logic                       corr_sat;

   pcs_multiplier u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product_ff)
   );

   pcs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_chan.elapsed_ms == '0) begin
         ms_clamped = MSC_W'(1);
      end else if (req_chan.elapsed_ms > MS_W'(MS_MAX)) begin
         ms_clamped = MSC_W'(MS_MAX);
      end else begin
         ms_clamped = req_chan.elapsed_ms[MSC_W-1:0];
      end
   end

   assign prod_mag = product_ff[PROD_W-1] ? PROD_W'(-product_ff) : PROD_W'(product_ff);

   assign acc_sum = (ACC_W+1)'(acc_ff) + product_ff[ACC_W:0];

   always_comb begin
      if (acc_sum > ACC_LIMIT) begin
         acc_sat = ACC_LIMIT;
      end else if (acc_sum < -ACC_LIMIT) begin
         acc_sat = -ACC_LIMIT;
      end else begin
         acc_sat = acc_sum;
      end
   end

   // Quotients come back as magnitudes; the sign of the dividend restores
   // truncation toward zero.
   assign quo_ext  = {1'b0, div_rsp.quotient};
   assign quo_term = ((state_ff == ST_I_DIV) ? ineg_ff : dneg_ff) ? -quo_ext : quo_ext;

   // Division by 256 truncated toward zero: bias negative sums before the shift.
   assign sum_biased = sum_ff[SUM_W-1] ? (sum_ff + SUM_W'(OUT_ROUND)) : sum_ff;
   assign sum_scaled = sum_biased >>> OUT_SHIFT;

   always_comb begin
      if (sum_scaled > SUM_W'(OUT_LIMIT)) begin
         corr_value = CORR_W'(OUT_LIMIT);
         corr_sat   = 1'b1;
      end else if (sum_scaled < SUM_W'(-OUT_LIMIT)) begin
         corr_value = CORR_W'(-OUT_LIMIT);
         corr_sat   = 1'b1;
      end else begin
         corr_value = CORR_W'(sum_scaled);
         corr_sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      mul_a            = MUL_A_W'(err_ff);
      mul_b            = MUL_B_W'(signed'({1'b0, ms_ff}));
      div_req.start    = 1'b0;
      div_req.dividend = dnum_ff;
      div_req.divisor  = ms_ff;
      rsp_load         = 1'b0;
      quo_take         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = primed_ff ? ST_ACC_MUL : ST_OUTPUT;
            end
         end
         ST_ACC_MUL: begin
            state_in = ST_ACC_UPD;
         end
         ST_ACC_UPD: begin
            mul_b    = signed'({1'b0, prop_ff});
            state_in = ST_P_TERM;
         end
         ST_P_TERM: begin
            mul_a    = MUL_A_W'(acc_ff);
            mul_b    = signed'({1'b0, integ_ff});
            state_in = ST_I_TERM;
         end
         ST_I_TERM: begin
            mul_a            = MUL_A_W'(diff_ff);
            mul_b            = signed'({1'b0, deriv_ff});
            div_req.start    = 1'b1;
            div_req.dividend = prod_mag[DIV_W-1:0];
            div_req.divisor  = MSC_W'(INTEG_SCALE);
            state_in         = ST_D_GAIN;
         end
         ST_D_GAIN: begin
            mul_a    = product_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(MS_SCALE);
            state_in = ST_D_TERM;
         end
         ST_D_TERM: begin
            state_in = ST_I_DIV;
         end
         ST_I_DIV: begin
            if (!div_rsp.busy) begin
               quo_take      = 1'b1;
               div_req.start = 1'b1;
               state_in      = ST_D_DIV;
            end
         end
         ST_D_DIV: begin
            if (!div_rsp.busy) begin
               quo_take = 1'b1;
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff  <= PROP_GAIN_RESET;
         integ_ff <= INTEG_GAIN_RESET;
         deriv_ff <= DERIV_GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_ff <= csr_wdata;
            CSR_DERIV_GAIN: deriv_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         prev_ff   <= '0;
         acc_ff    <= '0;
      end else begin
         if (req_fire) begin
            primed_ff <= 1'b1;
            prev_ff   <= req_chan.line_error;
         end
         if (state_ff == ST_ACC_UPD) begin
            acc_ff <= ACC_W'(acc_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff  <= req_chan.line_error;
         ms_ff   <= ms_clamped;
         diff_ff <= DIFF_W'(req_chan.line_error) - DIFF_W'(prev_ff);
         sum_ff  <= '0;
      end else if (state_ff == ST_P_TERM) begin
         sum_ff <= SUM_W'(product_ff);
      end else if (quo_take) begin
         sum_ff <= sum_ff + SUM_W'(quo_term);
      end
      if (state_ff == ST_I_TERM) begin
         ineg_ff <= product_ff[PROD_W-1];
      end
      if (state_ff == ST_D_TERM) begin
         dnum_ff <= prod_mag[DIV_W-1:0];
         dneg_ff <= product_ff[PROD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_corr_ff <= corr_value;
         rsp_sat_ff  <= corr_sat;
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.correction       = rsp_corr_ff;
   assign rsp_chan.output_saturated = rsp_sat_ff;

   `PCS_ASSERT_IMPL(a_sat_at_limit, clock, reset, rsp_valid_ff && rsp_sat_ff, (rsp_corr_ff == CORR_W'(OUT_LIMIT)) || (rsp_corr_ff == CORR_W'(-OUT_LIMIT)))
   `PCS_ASSERT_NEXT(a_first_zero, clock, reset, req_fire && !primed_ff, (state_ff == ST_OUTPUT) && (sum_ff == '0))
   `PCS_ASSERT_NEXT(a_acc_bound, clock, reset, state_ff == ST_ACC_UPD, ((ACC_W+1)'(acc_ff) <= ACC_LIMIT) && ((ACC_W+1)'(acc_ff) >= -ACC_LIMIT))

endmodule
